// ===== src/itaf_pkg.sv =====
// Package: word types, job descriptor, character codes and digit lookup for the formatter.
`timescale 1ns / 1ps
`default_nettype none
package itaf_pkg;

	// Widest printed number, sign included
	localparam int MAX_WIDTH = 63;
	// Width of counts and character positions
	localparam int LEN_W = 6;
	// BCD digits held for a 64-bit magnitude
	localparam int NDIG = 20;
	localparam int NDIG_W = 5;
	localparam int DIG_W = NDIG * 4;
	// Bits converted per word in use
	localparam int VAL_W = 64;
	localparam int BITS_WIDE = 64;
	localparam int BITS_NARROW = 32;
	localparam int BCNT_W = 7;
	// Job queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Character codes
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_PLUS = 7'h2B;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_ZERO = 7'h30;
	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam logic [6:0] CH_LOWER_A = 7'h61;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             signed_mode;
		logic             wide_mode;
		logic             hex_mode;
		logic             upper_digits;
		logic             space_sign;
		logic             plus_sign;
		logic             zero_pad;
		logic [5:0]       min_width;
	} in_word_t;

	typedef struct packed {
		logic [6:0] character;
		logic       last_char;
	} out_word_t;

	typedef logic [NDIG-1:0][3:0] digit_vec_t;

	// One classified number, ready to be printed
	typedef struct packed {
		digit_vec_t        digits;
		logic [NDIG_W-1:0] ndig;
		logic              has_sign;
		logic [6:0]        sign_char;
		logic              upper;
		logic              zpad;
		logic [LEN_W-1:0]  pad;
		logic [LEN_W-1:0]  total;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_DONE
	} front_state_t;

	// Digit value to ASCII, hex letters in the chosen case
	function automatic logic [6:0] digit_char(input logic [3:0] nib, input logic upper);
		logic [6:0] base;
		base = upper ? CH_UPPER_A : CH_LOWER_A;
		if (nib < 4'd10) begin
			digit_char = CH_ZERO + {3'b000, nib};
		end else begin
			digit_char = base + {3'b000, nib} - 7'd10;
		end
	endfunction

endpackage
`default_nettype wire

// ===== src/itaf_front.sv =====
// Front part: takes a number, works out sign and magnitude, converts to digits, builds a job.
`timescale 1ns / 1ps
`default_nettype none
module itaf_front
	import itaf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_word_t item,
	output logic          q_push,
	input  wire logic     q_full,
	output job_t          q_job
);

	front_state_t state_q, state_d;

	logic [VAL_W-1:0]  shift_q;
	digit_vec_t        bcd_q;
	logic [BCNT_W-1:0] cnt_q;
	logic              upper_q;
	logic              zpad_q;
	logic [5:0]        width_q;
	logic              has_sign_q;
	logic [6:0]        sign_q;

	logic              accept;
	logic              neg;
	logic [31:0]       low_word;
	logic [31:0]       low_mag;
	logic [VAL_W-1:0]  mag;
	logic              sgn_any;
	logic [6:0]        sgn_char;
	digit_vec_t        adj;
	logic [DIG_W-1:0]  adj_flat;
	logic [NDIG_W-1:0] ndig;
	logic [LEN_W-1:0]  width_sat;
	logic [LEN_W-1:0]  used;
	logic [LEN_W-1:0]  pad;

	assign full = (state_q != F_IDLE);
	assign accept = push && !full;

	// Sign and magnitude of the word in use
	always_comb begin
		low_word = item.value[31:0];
		low_mag = 32'd0 - low_word;
		if (item.wide_mode) begin
			neg = item.signed_mode && item.value[VAL_W-1];
			mag = neg ? ({VAL_W{1'b0}} - item.value) : item.value;
		end else begin
			neg = item.signed_mode && low_word[31];
			mag = {32'd0, neg ? low_mag : low_word};
		end
		sgn_any = 1'b1;
		sgn_char = CH_MINUS;
		if (!neg) begin
			if (item.signed_mode && item.space_sign) begin
				sgn_char = CH_SPACE;
			end else if (item.signed_mode && item.plus_sign) begin
				sgn_char = CH_PLUS;
			end else begin
				sgn_any = 1'b0;
			end
		end
	end

	// Shift-and-add-3 correction of every BCD digit
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
		adj_flat = adj;
	end

	// Digit count, padding and total length
	always_comb begin
		ndig = NDIG_W'(1);
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i] != 4'd0) begin
				ndig = NDIG_W'(i + 1);
			end
		end
		width_sat = (width_q > LEN_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH) : width_q;
		used = {1'b0, ndig} + {{(LEN_W-1){1'b0}}, has_sign_q};
		pad = (width_sat > used) ? (width_sat - used) : '0;
		q_job.digits = bcd_q;
		q_job.ndig = ndig;
		q_job.has_sign = has_sign_q;
		q_job.sign_char = sign_q;
		q_job.upper = upper_q;
		q_job.zpad = zpad_q;
		q_job.pad = pad;
		q_job.total = used + pad;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		q_push = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = item.hex_mode ? F_DONE : F_CONV;
				end
			end
			F_CONV: begin
				if (cnt_q == BCNT_W'(1)) begin
					state_d = F_DONE;
				end
			end
			F_DONE: begin
				if (!q_full) begin
					q_push = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Conversion datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			upper_q <= item.upper_digits;
			zpad_q <= item.zero_pad;
			width_q <= item.min_width;
			has_sign_q <= sgn_any;
			sign_q <= sgn_char;
			if (item.hex_mode) begin
				bcd_q <= {{(DIG_W-VAL_W){1'b0}}, mag};
			end else begin
				bcd_q <= '0;
			end
			shift_q <= item.wide_mode ? mag : {mag[31:0], 32'd0};
			cnt_q <= item.wide_mode ? BCNT_W'(BITS_WIDE) : BCNT_W'(BITS_NARROW);
		end else if (state_q == F_CONV) begin
			bcd_q <= {adj_flat[DIG_W-2:0], shift_q[VAL_W-1]};
			shift_q <= {shift_q[VAL_W-2:0], 1'b0};
			cnt_q <= cnt_q - BCNT_W'(1);
		end
	end

`ifndef ASSERT_OFF
	a_conv_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_CONV |-> cnt_q != '0)
		else $error("conversion running with an empty bit count");
	a_done_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DONE && !q_full) |=> state_q == F_IDLE)
		else $error("finished job not handed to the queue");
`endif

endmodule
`default_nettype wire

// ===== src/itaf_jobq.sv =====
// Two-entry job queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module itaf_jobq
	import itaf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire job_t wr_job,
	output logic      q_full,
	input  wire logic rd_en,
	output job_t      rd_job,
	output logic      q_empty
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full = (cnt_q == QCNT_W'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_job = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("job queue fill count out of range");
`endif

endmodule
`default_nettype wire

// ===== src/itaf_back.sv =====
// Back part: prints one job into the output register, a character per cycle while results are taken.
`timescale 1ns / 1ps
`default_nettype none
module itaf_back
	import itaf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t q_job,
	input  wire logic q_empty,
	output logic      q_pop,
	output logic      empty,
	input  wire logic pop,
	output out_word_t result
);

	job_t             job_q;
	logic             active_q;
	logic [LEN_W-1:0] k_q;
	out_word_t        out_q;
	logic             out_valid_q;

	logic             emit;
	logic [LEN_W-1:0] dstart;
	logic [LEN_W-1:0] rem;
	logic [NDIG_W-1:0] didx;
	logic [LEN_W-1:0] sign_pos;
	logic             last;
	logic [6:0]       ch;

	assign emit = active_q && (!out_valid_q || pop);
	assign q_pop = !active_q && !q_empty;
	assign empty = !out_valid_q;
	assign result = out_q;

	// Character at the current position
	always_comb begin
		dstart = job_q.total - {1'b0, job_q.ndig};
		rem = job_q.total - LEN_W'(1) - k_q;
		didx = rem[NDIG_W-1:0];
		sign_pos = job_q.zpad ? '0 : job_q.pad;
		last = (k_q == job_q.total - LEN_W'(1));
		if (k_q >= dstart) begin
			ch = digit_char(job_q.digits[didx], job_q.upper);
		end else if (job_q.has_sign && k_q == sign_pos) begin
			ch = job_q.sign_char;
		end else begin
			ch = job_q.zpad ? CH_ZERO : CH_SPACE;
		end
	end

	// Job and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				k_q <= '0;
			end else if (emit) begin
				k_q <= k_q + LEN_W'(1);
				if (last) begin
					active_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (emit) begin
			out_q.character <= ch;
			out_q.last_char <= last;
		end
	end

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> k_q < job_q.total)
		else $error("character position beyond the end of the number");
	a_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (job_q.ndig != '0 && job_q.ndig <= NDIG_W'(NDIG)))
		else $error("job without a valid digit count");
`endif

endmodule
`default_nettype wire

// ===== src/integer_to_ascii_formatter_top.sv =====
// Top level of the integer to ASCII formatter: front, job queue and back.
`timescale 1ns / 1ps
`default_nettype none
// Prints one 64- or 32-bit integer per input word as ASCII characters, most
// significant first, with last_char set on the final one. The front takes a
// word when full is low and holds it while it converts: a hex number is taken
// as it is, a decimal one goes through a one-bit-per-cycle shift-and-add-3 BCD
// converter, so that converter sets the input rate.
// Finished numbers wait in a two-entry queue; the back loads one when the last
// is printed, then prints one character per cycle (1 to 63 per number) while
// results are taken, so the next conversion overlaps the current printing.
// Results come out as a queue: a character is shown while empty is low and
// taken with pop; a held result stalls the front only once both queue
// entries are taken, and then the front keeps full high until one frees up.
module integer_to_ascii_formatter_top
	import itaf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_word_t item,
	output logic          empty,
	input  wire logic     pop,
	output out_word_t     result
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t front_job;
	job_t back_job;

	itaf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (q_push),
		.q_full (q_full),
		.q_job  (front_job)
	);

	itaf_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_job  (front_job),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_job  (back_job),
		.q_empty (q_empty)
	);

	itaf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_job   (back_job),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
`default_nettype wire
